// ===== rtl/dhot_pkg.sv =====
// Package for the double-hashing open table: state, operation, status and slot codes.
`default_nettype none
package dhot_pkg;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_FIRST,
    S_PROBE,
    S_WRITE
  } state_t;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_PRESENT  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] SLOT_EMPTY    = 2'd0;
  localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
  localparam logic [1:0] SLOT_VACATED  = 2'd2;

  localparam int HASH_BITS = 16;
  localparam int KEY_PORT_BITS = 32;
  localparam int COUNT_PORT_BITS = 11;

endpackage
`default_nettype wire

// ===== rtl/dhot_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module dhot_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/double_hash_open_table_unit.sv =====
// Top level of the double-hashing open-addressed key table.
`default_nettype none
// A request (op, key, hash1, hash2) is taken when start is high and busy is low;
// exactly one result follows, shown on status, found_key and count for the single
// cycle in which done is high, and the receiver must take it then. After reset the
// block sweeps the slot memory to empty, one slot per cycle, so busy stays high until
// every slot is cleared. A request then runs the hash reduction, a first read at the
// reduced hash1 and a probe of P slots (one memory read per cycle, at least one), then
// the write and result. The reduction is empty when POSITIONS is a power of two,
// otherwise it is 17 - clog2(POSITIONS) steps of compare and subtract. An unused op code
// or an insert into a full table skips the reduction and probe and goes straight to the
// write. The probe walk through the slot memory, with its one read per cycle, sets the rate.
module double_hash_open_table_unit #(
  parameter int POSITIONS = 1024,
  parameter int KEY_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [31:0] key,
  input  wire logic [15:0] hash1,
  input  wire logic [15:0] hash2,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      found_key,
  output logic [10:0]      count
);

  localparam int PW   = $clog2(POSITIONS);
  localparam int CW   = $clog2(POSITIONS + 1);
  localparam int SW   = (KEY_BITS < dhot_pkg::KEY_PORT_BITS) ? KEY_BITS
                                                              : dhot_pkg::KEY_PORT_BITS;
  localparam int HW   = dhot_pkg::HASH_BITS;
  localparam int RW   = HW + 1;
  localparam int KSTEPS = (PW < HW) ? HW - PW : 0;
  localparam int MW   = SW + 2;

  dhot_pkg::state_t state, state_next;

  logic [1:0]    op_r, op_r_next;
  logic [SW-1:0] key_r, key_r_next;
  logic [RW-1:0] r1, r1_next, r2, r2_next;
  logic [3:0]    kstep, kstep_next;
  logic [PW-1:0] cur, cur_next;
  logic [PW-1:0] cnt, cnt_next;
  logic          free_ok, free_ok_next;
  logic [PW-1:0] free_pos, free_pos_next;
  logic [CW-1:0] count_r, count_r_next;
  logic [1:0]    status_r, status_r_next;
  logic [SW-1:0] fkey_r, fkey_r_next;
  logic          wr_en, wr_en_next;
  logic [PW-1:0] wr_addr, wr_addr_next;
  logic [MW-1:0] wr_data, wr_data_next;
  logic [PW-1:0] clr_idx, clr_idx_next;
  logic          done_r, done_r_next;

  logic          ram_we;
  logic [PW-1:0] ram_waddr, rd_addr;
  logic [MW-1:0] ram_wdata, rdata;

  logic [1:0]    rd_st;
  logic [SW-1:0] rd_key;
  logic          hit, at_empty, at_last, free_now;
  logic [PW:0]   sum;
  logic [PW-1:0] nxt;
  logic [RW-1:0] sub;

  dhot_ram #(
    .WIDTH (MW),
    .DEPTH (POSITIONS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign ram_we    = (state == dhot_pkg::S_CLEAR) || ((state == dhot_pkg::S_WRITE) && wr_en);
  assign ram_waddr = (state == dhot_pkg::S_CLEAR) ? clr_idx : wr_addr;
  assign ram_wdata = (state == dhot_pkg::S_CLEAR) ? {dhot_pkg::SLOT_EMPTY, {SW{1'b0}}}
                                                  : wr_data;

  assign rd_st    = rdata[SW +: 2];
  assign rd_key   = rdata[SW-1:0];
  assign hit      = (rd_st == dhot_pkg::SLOT_OCCUPIED) && (rd_key == key_r);
  assign at_empty = (rd_st == dhot_pkg::SLOT_EMPTY);
  assign free_now = (rd_st != dhot_pkg::SLOT_OCCUPIED);
  assign at_last  = (cnt == PW'(POSITIONS - 1));

  // Next probe position: cur and step are both below POSITIONS, so one subtract wraps it.
  assign sum = {1'b0, cur} + {1'b0, r2[PW-1:0]};
  assign nxt = (sum >= (PW+1)'(POSITIONS)) ? PW'(sum - (PW+1)'(POSITIONS)) : sum[PW-1:0];

  assign sub = RW'(POSITIONS) << kstep;

  assign busy      = (state != dhot_pkg::S_IDLE);
  assign done      = done_r;
  assign status    = status_r;
  assign found_key = dhot_pkg::KEY_PORT_BITS'(fkey_r);
  assign count     = dhot_pkg::COUNT_PORT_BITS'(count_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= dhot_pkg::S_CLEAR;
      clr_idx <= '0;
      count_r <= '0;
      done_r  <= 1'b0;
      wr_en   <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      count_r <= count_r_next;
      done_r  <= done_r_next;
      wr_en   <= wr_en_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_r_next;
    key_r    <= key_r_next;
    r1       <= r1_next;
    r2       <= r2_next;
    kstep    <= kstep_next;
    cur      <= cur_next;
    cnt      <= cnt_next;
    free_ok  <= free_ok_next;
    free_pos <= free_pos_next;
    status_r <= status_r_next;
    fkey_r   <= fkey_r_next;
    wr_addr  <= wr_addr_next;
    wr_data  <= wr_data_next;
  end

  always_comb begin
    state_next    = state;
    op_r_next     = op_r;
    key_r_next    = key_r;
    r1_next       = r1;
    r2_next       = r2;
    kstep_next    = kstep;
    cur_next      = cur;
    cnt_next      = cnt;
    free_ok_next  = free_ok;
    free_pos_next = free_pos;
    count_r_next  = count_r;
    status_r_next = status_r;
    fkey_r_next   = fkey_r;
    wr_en_next    = wr_en;
    wr_addr_next  = wr_addr;
    wr_data_next  = wr_data;
    clr_idx_next  = clr_idx;
    done_r_next   = 1'b0;
    rd_addr       = cur;

    unique case (state)
      dhot_pkg::S_CLEAR: begin
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == PW'(POSITIONS - 1)) begin
          state_next = dhot_pkg::S_IDLE;
        end
      end

      dhot_pkg::S_IDLE: begin
        if (start) begin
          op_r_next     = op;
          key_r_next    = key[SW-1:0];
          r1_next       = {1'b0, hash1};
          r2_next       = {1'b0, hash2};
          kstep_next    = 4'(KSTEPS);
          fkey_r_next   = '0;
          wr_en_next    = 1'b0;
          status_r_next = dhot_pkg::ST_NOTFOUND;
          if ((op != dhot_pkg::OP_INSERT) && (op != dhot_pkg::OP_REMOVE) &&
              (op != dhot_pkg::OP_LOOKUP)) begin
            state_next = dhot_pkg::S_WRITE;
          end else if ((op == dhot_pkg::OP_INSERT) && (count_r == CW'(POSITIONS))) begin
            status_r_next = dhot_pkg::ST_FULL;
            state_next    = dhot_pkg::S_WRITE;
          end else if ((POSITIONS & (POSITIONS - 1)) == 0) begin
            state_next = dhot_pkg::S_FIRST;
          end else begin
            state_next = dhot_pkg::S_REDUCE;
          end
        end
      end

      // Reduce both hashes modulo POSITIONS, one shifted compare and subtract per cycle.
      dhot_pkg::S_REDUCE: begin
        if (r1 >= sub) begin
          r1_next = r1 - sub;
        end
        if (r2 >= sub) begin
          r2_next = r2 - sub;
        end
        kstep_next = kstep - 1'b1;
        if (kstep == 4'd0) begin
          state_next = dhot_pkg::S_FIRST;
        end
      end

      dhot_pkg::S_FIRST: begin
        rd_addr      = r1[PW-1:0];
        cur_next     = r1[PW-1:0];
        cnt_next     = '0;
        free_ok_next = 1'b0;
        state_next   = dhot_pkg::S_PROBE;
      end

      dhot_pkg::S_PROBE: begin
        if (hit) begin
          state_next = dhot_pkg::S_WRITE;
          case (op_r)
            dhot_pkg::OP_INSERT: begin
              status_r_next = dhot_pkg::ST_PRESENT;
            end
            dhot_pkg::OP_REMOVE: begin
              status_r_next = dhot_pkg::ST_DONE;
              fkey_r_next   = rd_key;
              wr_en_next    = 1'b1;
              wr_addr_next  = cur;
              wr_data_next  = {dhot_pkg::SLOT_VACATED, rd_key};
              count_r_next  = count_r - 1'b1;
            end
            default: begin
              status_r_next = dhot_pkg::ST_DONE;
              fkey_r_next   = rd_key;
            end
          endcase
        end else if (at_empty || at_last) begin
          // The walk ended without a match; an insert takes the first free slot it passed.
          state_next = dhot_pkg::S_WRITE;
          if (op_r == dhot_pkg::OP_INSERT) begin
            if (free_ok || free_now) begin
              status_r_next = dhot_pkg::ST_DONE;
              wr_en_next    = 1'b1;
              wr_addr_next  = free_ok ? free_pos : cur;
              wr_data_next  = {dhot_pkg::SLOT_OCCUPIED, key_r};
              count_r_next  = count_r + 1'b1;
            end else begin
              status_r_next = dhot_pkg::ST_FULL;
            end
          end else begin
            status_r_next = dhot_pkg::ST_NOTFOUND;
          end
        end else begin
          rd_addr  = nxt;
          cur_next = nxt;
          cnt_next = cnt + 1'b1;
          if (!free_ok && free_now) begin
            free_ok_next  = 1'b1;
            free_pos_next = cur;
          end
        end
      end

      dhot_pkg::S_WRITE: begin
        done_r_next = 1'b1;
        wr_en_next  = 1'b0;
        state_next  = dhot_pkg::S_IDLE;
      end

      default: begin
        state_next = dhot_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
